>>> sv/frame_page_pool_manager_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame page pool manager
// Clocked, reset-gated property checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FRAME_PAGE_POOL_MANAGER_UNIT_ASSERT_SVH
`define FRAME_PAGE_POOL_MANAGER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FPPM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fppm check failed");

// Next-cycle implication.
`define FPPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fppm check failed");

`endif

>>> sv/fppm_pkg.sv
// ----------------------------------------------------------------------------
// Frame page pool manager package
// Field widths, opcodes and fixed constants shared by the design files.
// ----------------------------------------------------------------------------
package fppm_pkg;

  localparam int PAGE_W = 6;
  localparam int OPC_W  = 2;

  typedef logic [OPC_W-1:0]  opcode_t;
  typedef logic [PAGE_W-1:0] page_t;

  localparam opcode_t OP_ALLOC = 2'd0;
  localparam opcode_t OP_LINK  = 2'd1;
  localparam opcode_t OP_DEL4  = 2'd2;

  localparam int DELETE_ORDINAL = 4;
  localparam int ORD_W          = $clog2(DELETE_ORDINAL);

endpackage

>>> sv/fppm_if.sv
// ----------------------------------------------------------------------------
// Frame page pool manager channels
// Command and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
interface fppm_cmd_if;
  import fppm_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t opcode;
  page_t   page_index;
  logic    page_present;

  modport source (output valid, opcode, page_index, page_present, input ready);
  modport sink   (input valid, opcode, page_index, page_present, output ready);
endinterface

interface fppm_rsp_if;
  import fppm_pkg::*;

  logic  valid;
  logic  ready;
  page_t result_page;
  logic  result_present;
  page_t freed_page;
  logic  freed_present;
  logic  error_code;

  modport source (output valid, result_page, result_present, freed_page,
                  freed_present, error_code, input ready);
  modport sink   (input valid, result_page, result_present, freed_page,
                  freed_present, error_code, output ready);
endinterface

>>> sv/fppm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fppm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/frame_page_pool_manager_unit.sv
// ----------------------------------------------------------------------------
// Frame page pool manager
// Active frame list, quarantined free FIFO and a link-walking sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one operation per beat (allocate, link at head, delete
//   fourth); rsp returns exactly one beat per command with the allocated
//   or following page, the page freed by the command and an error flag.
//   cmd.ready is high only while the sequencer is idle; one command is in
//   flight at a time.
//   Path from command beat to response valid, with rsp free:
//     link or null/unknown command: straight to S_DONE
//     allocate with a drawable page: S_POP_RD, S_POP, then S_DONE
//     allocate with forced eviction: S_WALK over at most POOL_PAGES links
//       (one link followed per cycle through the link RAM), then S_POP_RD,
//       S_POP and S_DONE
//     delete-fourth: S_DEL to the fourth page, S_DEL_FIX, then S_DONE
//   The link walk reads one next pointer per cycle from the link RAM port.
//   Reset clears the list, the FIFO pointers and all link/fill flags at
//   once; no clearing pass. A stalled rsp holds its beat; the next command
//   is accepted and worked on, and its result waits until rsp drains.
// ----------------------------------------------------------------------------
module frame_page_pool_manager_unit #(
  parameter int POOL_PAGES        = 48,
  parameter int DRAWABLE_AT_RESET = 36
) (
  input  logic              clk,
  input  logic              rst,
  fppm_cmd_if.sink          cmd,
  fppm_rsp_if.source        rsp
);
  import fppm_pkg::*;

  localparam int IW  = $clog2(POOL_PAGES);
  localparam int SW  = $clog2(POOL_PAGES + 1);
  localparam int CMX = (POOL_PAGES > DRAWABLE_AT_RESET) ? POOL_PAGES : DRAWABLE_AT_RESET;
  localparam int CW  = $clog2(CMX + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_WALK    = 3'd1;
  localparam logic [2:0] S_POP_RD  = 3'd2;
  localparam logic [2:0] S_POP     = 3'd3;
  localparam logic [2:0] S_DEL     = 3'd4;
  localparam logic [2:0] S_DEL_FIX = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0]            state;
  logic [POOL_PAGES-1:0] link_ok;
  logic [POOL_PAGES-1:0] ring_written;
  logic [IW-1:0]         head;
  logic                  head_ok;
  logic [IW-1:0]         rd_pos;
  logic [IW-1:0]         wr_pos;
  logic [CW-1:0]         drawable;
  logic [IW-1:0]         cur_reg;
  logic [IW-1:0]         prev;
  logic                  use_rdata;
  logic [SW-1:0]         steps;
  logic [ORD_W-1:0]      ord;
  logic                  ring_hit;

  logic [IW-1:0]         pend_res;
  logic                  pend_res_ok;
  logic [IW-1:0]         pend_freed;
  logic                  pend_freed_ok;
  logic                  pend_err;

  logic [IW-1:0]         cur_w;
  logic [IW-1:0]         pidx;
  logic                  pidx_ok;
  logic                  list_we;
  logic [IW-1:0]         list_waddr;
  logic [IW-1:0]         list_wdata;
  logic [IW-1:0]         list_rdata;
  logic                  push;
  logic [IW-1:0]         push_page;
  logic [IW-1:0]         ring_rdata;
  logic [IW-1:0]         pop_page;
  logic [IW-1:0]         wr_pos_next;
  logic [IW-1:0]         rd_pos_next;

  fppm_ram #(.WIDTH(IW), .DEPTH(POOL_PAGES)) u_link_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .raddr (cur_w),
    .rdata (list_rdata)
  );

  fppm_ram #(.WIDTH(IW), .DEPTH(POOL_PAGES)) u_ring_ram (
    .clk   (clk),
    .we    (push),
    .waddr (wr_pos),
    .wdata (push_page),
    .raddr (rd_pos),
    .rdata (ring_rdata)
  );

  assign cmd.ready   = (state == S_IDLE);
  assign pidx        = IW'(cmd.page_index);
  assign pidx_ok     = cmd.page_present && (32'(cmd.page_index) < POOL_PAGES);
  assign cur_w       = use_rdata ? list_rdata : cur_reg;
  assign pop_page    = ring_hit ? ring_rdata : rd_pos;
  assign wr_pos_next = (wr_pos == IW'(POOL_PAGES - 1)) ? '0 : wr_pos + 1'b1;
  assign rd_pos_next = (rd_pos == IW'(POOL_PAGES - 1)) ? '0 : rd_pos + 1'b1;

  always_comb begin
    list_we    = 1'b0;
    list_waddr = prev;
    list_wdata = list_rdata;
    push       = 1'b0;
    push_page  = cur_reg;
    case (state)
      S_IDLE: begin
        if (cmd.valid && cmd.opcode == OP_LINK && pidx_ok) begin
          list_we    = 1'b1;
          list_waddr = pidx;
          list_wdata = head;
        end
      end
      S_WALK: begin
        if (steps != SW'(POOL_PAGES) && !link_ok[cur_w] && steps != '0) begin
          push      = 1'b1;
          push_page = cur_w;
        end
      end
      S_DEL_FIX: begin
        list_we = 1'b1;
        push    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      link_ok      <= '0;
      ring_written <= '0;
      head         <= '0;
      head_ok      <= 1'b0;
      rd_pos       <= '0;
      wr_pos       <= '0;
      drawable     <= CW'(DRAWABLE_AT_RESET);
      use_rdata    <= 1'b0;
      rsp.valid    <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      if (push) begin
        ring_written[wr_pos] <= 1'b1;
        wr_pos <= wr_pos_next;
        if (drawable < CW'(POOL_PAGES)) begin
          drawable <= drawable + 1'b1;
        end
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            pend_res      <= '0;
            pend_res_ok   <= 1'b0;
            pend_freed    <= '0;
            pend_freed_ok <= 1'b0;
            pend_err      <= (cmd.opcode == OP_ALLOC) && (drawable == '0) && !head_ok;
            case (cmd.opcode)
              OP_ALLOC: begin
                if (drawable != '0) begin
                  state <= S_POP_RD;
                end else if (!head_ok) begin
                  state <= S_DONE;
                end else begin
                  cur_reg   <= head;
                  use_rdata <= 1'b0;
                  steps     <= '0;
                  state     <= S_WALK;
                end
              end
              OP_LINK: begin
                if (pidx_ok) begin
                  link_ok[pidx] <= head_ok;
                  head          <= pidx;
                  head_ok       <= 1'b1;
                end
                state <= S_DONE;
              end
              OP_DEL4: begin
                if (pidx_ok) begin
                  cur_reg   <= pidx;
                  use_rdata <= 1'b0;
                  ord       <= '0;
                  state     <= S_DEL;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_WALK: begin
          if (steps == SW'(POOL_PAGES)) begin
            pend_err <= 1'b1;
            state    <= S_DONE;
          end else if (!link_ok[cur_w]) begin
            if (steps != '0) begin
              link_ok[prev] <= 1'b0;
              pend_freed    <= cur_w;
              pend_freed_ok <= 1'b1;
              state         <= S_POP_RD;
            end else begin
              pend_err <= 1'b1;
              state    <= S_DONE;
            end
          end else begin
            prev      <= cur_w;
            use_rdata <= 1'b1;
            steps     <= steps + 1'b1;
          end
        end
        S_POP_RD: begin
          ring_hit <= ring_written[rd_pos];
          state    <= S_POP;
        end
        S_POP: begin
          link_ok[pop_page] <= 1'b0;
          rd_pos            <= rd_pos_next;
          drawable          <= drawable - 1'b1;
          pend_res          <= pop_page;
          pend_res_ok       <= 1'b1;
          state             <= S_DONE;
        end
        S_DEL: begin
          if (ord == ORD_W'(DELETE_ORDINAL - 1)) begin
            cur_reg   <= cur_w;
            use_rdata <= 1'b0;
            state     <= S_DEL_FIX;
          end else if (!link_ok[cur_w]) begin
            state <= S_DONE;
          end else begin
            prev      <= cur_w;
            use_rdata <= 1'b1;
            ord       <= ord + 1'b1;
          end
        end
        S_DEL_FIX: begin
          link_ok[prev] <= link_ok[cur_reg];
          pend_freed    <= cur_reg;
          pend_freed_ok <= 1'b1;
          if (link_ok[cur_reg]) begin
            pend_res    <= list_rdata;
            pend_res_ok <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid          <= 1'b1;
            rsp.result_page    <= PAGE_W'(pend_res);
            rsp.result_present <= pend_res_ok;
            rsp.freed_page     <= PAGE_W'(pend_freed);
            rsp.freed_present  <= pend_freed_ok;
            rsp.error_code     <= pend_err;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `include "frame_page_pool_manager_unit_assert.svh"

  // a pop never runs on an empty drawable count
  `FPPM_ASSERT_NOW(a_pop_has_page, clk, rst, state == S_POP, drawable != '0)
  // an error beat carries no page
  `FPPM_ASSERT_NOW(a_err_no_page, clk, rst, rsp.valid && rsp.error_code,
                   !rsp.result_present && !rsp.freed_present)
  // an accepted command always starts work
  `FPPM_ASSERT_NEXT(a_cmd_starts, clk, rst, cmd.valid && cmd.ready, state != S_IDLE)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame page pool manager testbench
// Drives allocate, link and delete-fourth commands through the command
// channel and checks every response beat against an in-bench model of the
// page pool: active list links, quarantined free ring and drawable count.
// The stimulus mostly allocates pages and links them at the head, with
// deletes from list positions, allocate bursts that drain the pool into
// forced eviction, stray links that build cycles and foreign lists, and
// raw noise. Four traffic phases vary sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import fppm_pkg::*;

  localparam int POOL_PAGES        = 48;
  localparam int DRAWABLE_AT_RESET = 36;
  localparam int RANDOM_ITEMS      = 1750;
  localparam int DRAIN_CYCLES      = 60;
  localparam int CYCLE_LIMIT       = 1000000;

  localparam opcode_t OP_UNUSED = 2'd3;

  typedef struct packed {
    opcode_t op;
    page_t   page;
    logic    present;
  } page_cmd_t;

  typedef struct packed {
    page_t result_page;
    logic  result_present;
    page_t freed_page;
    logic  freed_present;
    logic  error_code;
  } page_rsp_t;

  typedef struct packed {
    logic [POOL_PAGES-1:0][PAGE_W-1:0] link;
    logic [POOL_PAGES-1:0]             link_ok;
    page_t                             head;
    logic                              head_ok;
    logic [POOL_PAGES-1:0][PAGE_W-1:0] ring;
    page_t                             rd_pos;
    page_t                             wr_pos;
    logic [6:0]                        avail;
  } pool_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fppm_cmd_if cmd_ch ();
  fppm_rsp_if rsp_ch ();

  frame_page_pool_manager_unit #(
    .POOL_PAGES        (POOL_PAGES),
    .DRAWABLE_AT_RESET (DRAWABLE_AT_RESET)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch.sink),
    .rsp (rsp_ch.source)
  );

  page_cmd_t   cmd_backlog[$];
  page_rsp_t   pending_results[$];
  pool_state_t plan_pool;
  pool_state_t shadow_pool;
  page_cmd_t   drive_cmd;
  page_rsp_t   want_rsp;
  logic        cmd_beat;
  int          src_idle_pct;
  int          sink_stall_pct;
  int          planned_items;
  int          fail_count;
  int          cycle_count;

  always #1 clk = ~clk;

  function automatic pool_state_t pool_reset();
    pool_state_t st;
    st = '0;
    for (int i = 0; i < POOL_PAGES; i++) begin
      st.ring[i] = page_t'(i);
    end
    st.avail = 7'(DRAWABLE_AT_RESET);
    return st;
  endfunction

  function automatic void ring_push(inout pool_state_t st, input int pg);
    st.ring[st.wr_pos] = page_t'(pg);
    st.wr_pos = page_t'((int'(st.wr_pos) + 1) % POOL_PAGES);
    if (st.avail < POOL_PAGES) begin
      st.avail = st.avail + 7'd1;
    end
  endfunction

  function automatic page_rsp_t pool_step(inout pool_state_t st, input page_cmd_t c);
    page_rsp_t r;
    int        cur;
    int        prev;
    int        steps;
    int        ctr;
    logic      has_prev;
    logic      found;
    logic      cur_ok;
    logic      done;
    logic      can_pop;
    logic      pvalid;
    r = '0;
    pvalid = c.present && (int'(c.page) < POOL_PAGES);
    case (c.op)
      OP_ALLOC: begin
        can_pop = 1'b1;
        if (st.avail == 0) begin
          cur = 0;
          prev = 0;
          steps = 0;
          has_prev = 1'b0;
          found = 1'b0;
          if (st.head_ok) begin
            cur = int'(st.head);
            while (steps < POOL_PAGES && !found) begin
              if (!st.link_ok[cur]) begin
                found = 1'b1;
              end else begin
                prev = cur;
                has_prev = 1'b1;
                cur = int'(st.link[cur]);
                steps++;
              end
            end
          end
          if (found && has_prev) begin
            st.link_ok[prev] = 1'b0;
            ring_push(st, cur);
            r.freed_page = page_t'(cur);
            r.freed_present = 1'b1;
          end else begin
            r.error_code = 1'b1;
            can_pop = 1'b0;
          end
        end
        if (can_pop) begin
          r.result_page = st.ring[st.rd_pos];
          r.result_present = 1'b1;
          st.rd_pos = page_t'((int'(st.rd_pos) + 1) % POOL_PAGES);
          st.avail = st.avail - 7'd1;
          st.link_ok[r.result_page] = 1'b0;
        end
      end
      OP_LINK: begin
        if (pvalid) begin
          st.link[c.page] = st.head;
          st.link_ok[c.page] = st.head_ok;
          st.head = c.page;
          st.head_ok = 1'b1;
        end
      end
      OP_DEL4: begin
        if (pvalid) begin
          cur = int'(c.page);
          prev = int'(c.page);
          ctr = 0;
          cur_ok = 1'b1;
          done = 1'b0;
          while (cur_ok && !done) begin
            ctr++;
            if (ctr == DELETE_ORDINAL) begin
              st.link[prev] = st.link[cur];
              st.link_ok[prev] = st.link_ok[cur];
              ring_push(st, cur);
              r.freed_page = page_t'(cur);
              r.freed_present = 1'b1;
              done = 1'b1;
            end else begin
              prev = cur;
              cur_ok = st.link_ok[cur];
              cur = int'(st.link[cur]);
            end
          end
          if (st.link_ok[prev]) begin
            r.result_page = st.link[prev];
            r.result_present = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Queues one command and advances the planning copy of the pool with it.
  function automatic page_rsp_t plan_cmd(opcode_t op, page_t pg, logic pr);
    page_cmd_t c;
    c.op = op;
    c.page = pg;
    c.present = pr;
    cmd_backlog.push_back(c);
    if (op == OP_ALLOC || ((op == OP_LINK || op == OP_DEL4) && pr &&
        int'(pg) < POOL_PAGES)) begin
      planned_items++;
    end
    return pool_step(plan_pool, c);
  endfunction

  function automatic void check_field(string name, int expv, int actv);
    if (expv != actv) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // driver: command beats and response stalls change on the falling edge
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_beat) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        drive_cmd = cmd_backlog.pop_front();
        cmd_ch.valid <= 1'b1;
        cmd_ch.opcode <= drive_cmd.op;
        cmd_ch.page_index <= drive_cmd.page;
        cmd_ch.page_present <= drive_cmd.present;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: accepted commands feed the model, responses pop the oldest result
  always @(posedge clk) begin
    if (rst) begin
      cmd_beat <= 1'b0;
    end else begin
      cmd_beat <= cmd_ch.valid && cmd_ch.ready;
      if (cmd_ch.valid && cmd_ch.ready) begin
        pending_results.push_back(pool_step(shadow_pool,
          '{op: cmd_ch.opcode, page: cmd_ch.page_index, present: cmd_ch.page_present}));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("response beat with no command outstanding");
          fail_count++;
        end else begin
          want_rsp = pending_results.pop_front();
          check_field("result_page", int'(want_rsp.result_page),
                      int'(rsp_ch.result_page));
          check_field("result_present", int'(want_rsp.result_present),
                      int'(rsp_ch.result_present));
          check_field("freed_page", int'(want_rsp.freed_page),
                      int'(rsp_ch.freed_page));
          check_field("freed_present", int'(want_rsp.freed_present),
                      int'(rsp_ch.freed_present));
          check_field("error_code", int'(want_rsp.error_code),
                      int'(rsp_ch.error_code));
        end
      end
    end
  end

  initial begin
    page_rsp_t got;
    page_t     start;
    int        pick;
    int        phase_goal;
    int        src_pct[4];
    int        sink_pct[4];
    src_pct = '{0, 60, 0, 10};
    sink_pct = '{0, 0, 60, 10};
    cmd_ch.valid = 1'b0;
    cmd_ch.opcode = OP_ALLOC;
    cmd_ch.page_index = '0;
    cmd_ch.page_present = 1'b0;
    rsp_ch.ready = 1'b0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    planned_items = 0;
    fail_count = 0;
    cycle_count = 0;
    plan_pool = pool_reset();
    shadow_pool = pool_reset();

    // directed: null and out-of-pool pages, unknown opcode, short lists, self loop
    void'(plan_cmd(OP_UNUSED, 6'd63, 1'b1));
    void'(plan_cmd(OP_LINK, 6'd5, 1'b0));
    void'(plan_cmd(OP_LINK, 6'd48, 1'b1));
    void'(plan_cmd(OP_DEL4, 6'd63, 1'b1));
    void'(plan_cmd(OP_DEL4, 6'd0, 1'b0));
    repeat (4) begin
      got = plan_cmd(OP_ALLOC, 6'd63, 1'b0);
      void'(plan_cmd(OP_LINK, got.result_page, 1'b1));
    end
    void'(plan_cmd(OP_DEL4, plan_pool.head, 1'b1));
    void'(plan_cmd(OP_DEL4, plan_pool.head, 1'b1));
    void'(plan_cmd(OP_DEL4, 6'd47, 1'b1));
    void'(plan_cmd(OP_LINK, 6'd47, 1'b1));
    void'(plan_cmd(OP_LINK, 6'd47, 1'b1));
    void'(plan_cmd(OP_DEL4, 6'd47, 1'b1));
    void'(plan_cmd(OP_ALLOC, 6'd0, 1'b1));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = src_pct[ph];
      sink_stall_pct = sink_pct[ph];
      phase_goal = planned_items + RANDOM_ITEMS / 4;
      while (planned_items < phase_goal) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          repeat ($urandom_range(1, 4)) begin
            got = plan_cmd(OP_ALLOC, page_t'($urandom_range(63)), 1'($urandom));
            if (got.result_present) begin
              void'(plan_cmd(OP_LINK, got.result_page, 1'b1));
            end
          end
        end else if (pick < 60) begin
          start = plan_pool.head_ok ? plan_pool.head : page_t'($urandom_range(47));
          repeat ($urandom_range(0, 3)) begin
            if (plan_pool.link_ok[start]) begin
              start = plan_pool.link[start];
            end
          end
          void'(plan_cmd(OP_DEL4, start, 1'b1));
        end else if (pick < 70) begin
          repeat ($urandom_range(4, 16)) begin
            void'(plan_cmd(OP_ALLOC, page_t'($urandom_range(63)), 1'($urandom)));
          end
        end else if (pick < 80) begin
          void'(plan_cmd(OP_LINK, page_t'($urandom_range(47)), 1'b1));
        end else if (pick < 90) begin
          void'(plan_cmd(OP_DEL4, page_t'($urandom_range(47)), 1'b1));
        end else begin
          void'(plan_cmd(opcode_t'($urandom_range(3)), page_t'($urandom_range(63)),
                         1'($urandom)));
        end
      end
      while (cmd_backlog.size() != 0 || cmd_ch.valid || pending_results.size() != 0) begin
        @(posedge clk);
      end
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
